// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== hdl/mbhd_pkg.sv =====
package mbhd_pkg;

    localparam int BUTTON_COUNT = 8;
    localparam int IDX_W        = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int BIDX_W       = 3;
    localparam int CODE_W       = 3;
    localparam int HIST_W       = 32;
    localparam int TIME_W       = 32;
    localparam int LEVEL_W      = 8;
    localparam int MASK_W       = 8;
    localparam int PS_W         = 5;

    localparam int MIN_PRESS_MS     = 60;
    localparam int SAMPLE_PERIOD_MS = 10;
    localparam logic [PS_W-1:0] PS_RESET = PS_W'(MIN_PRESS_MS / SAMPLE_PERIOD_MS);

    localparam logic [BIDX_W-1:0] LAST_INDEX = BIDX_W'(BUTTON_COUNT - 1);

    localparam int IN_W        = LEVEL_W + TIME_W;
    localparam int OUT_FIELD_W = BIDX_W + CODE_W + HIST_W + 2 * TIME_W;
    localparam int OUT_W       = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_W - OUT_FIELD_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_MASK   = 1'b0,
        REG_PRESS_SAMPLES = 1'b1
    } cfg_reg_t;

    typedef enum logic [CODE_W-1:0] {
        ST_UNKNOWN  = 3'd0,
        ST_PRESSED  = 3'd1,
        ST_RELEASED = 3'd2,
        ST_DOWN     = 3'd3,
        ST_UP       = 3'd4
    } state_code_t;

    // Controller to datapath.
    typedef struct packed {
        logic             load;
        logic             step;
        logic [IDX_W-1:0] idx;
        logic             last;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_hold;
    } stat_t;

endpackage

// ===== hdl/multi_button_history_debouncer_unit.sv =====
// Debounces up to eight buttons from one stream word per sample tick. Each input word
// carries the raw button levels and the current millisecond time; the block answers with
// one output word per button, in index order, the last one flagged by tlast and carrying
// all_up in tuser. A tick first takes the input word and then scans the buttons in index
// order, pausing while the output side stalls, since a single scan unit visits the buttons
// in turn and its word must enter the output register before the next button is scanned.
// Configuration (register 0 active_mask, register 1 press_samples) is to be written by
// the user between ticks; the block itself does not enforce this. cfg_ready is always high.
module multi_button_history_debouncer_unit
    import mbhd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // levels[7:0], now_ms[39:8]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // button_index[2:0], state_code[5:3], history_bits[37:6], press_time[69:38],
    // release_time[101:70], zero fill above
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser,   // all_up[0]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    mbhd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mbhd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== hdl/mbhd_ctrl.sv =====
module mbhd_ctrl
    import mbhd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic {
        IDLE,
        SCAN
    } fsm_t;

    fsm_t             state_reg;
    fsm_t             state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             is_last;

    assign is_last  = (idx_reg == IDX_W'(BUTTON_COUNT - 1));
    assign s_tready = (state_reg == IDLE);

    always_comb
    begin
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.idx    = idx_reg;
        cmd.last   = is_last;
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = SCAN;
                    idx_next   = '0;
                end
            end
            SCAN:
            begin
                // advance one button per cycle while the output register can take a word
                if (!stat.out_hold)
                begin
                    cmd.step = 1'b1;
                    if (is_last)
                    begin
                        state_next = IDLE;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== hdl/mbhd_datapath.sv =====
module mbhd_datapath
    import mbhd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic [IN_W-1:0]       s_tdata,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);

    // configuration
    logic [MASK_W-1:0] active_mask_reg;
    logic [PS_W-1:0]   press_samples_reg;

    // sampled tick
    logic [LEVEL_W-1:0] levels_reg;
    logic [TIME_W-1:0]  now_reg;

    // per-button state
    logic [HIST_W-1:0] hist_reg     [BUTTON_COUNT];
    logic              flag_reg     [BUTTON_COUNT];
    logic [TIME_W-1:0] press_at_reg [BUTTON_COUNT];
    logic [TIME_W-1:0] rel_at_reg   [BUTTON_COUNT];

    logic all_up_reg;

    // output register
    logic                out_valid_reg;
    logic [BIDX_W-1:0]   out_idx_reg;
    state_code_t         out_code_reg;
    logic [HIST_W-1:0]   out_hist_reg;
    logic [TIME_W-1:0]   out_press_reg;
    logic [TIME_W-1:0]   out_rel_reg;
    logic                out_all_up_reg;
    logic                out_last_reg;

    logic [BUTTON_COUNT-1:0] active_vec;
    logic [BUTTON_COUNT-1:0] level_vec;
    logic                    active;
    logic [PS_W-1:0]         n_eff;
    logic [HIST_W:0]         win_wide;
    logic [HIST_W-1:0]       win;
    logic [HIST_W-1:0]       ones_n;
    logic [HIST_W-1:0]       rel_pat;
    logic [HIST_W-1:0]       hist_new;
    logic [HIST_W-1:0]       h;
    logic                    is_press;
    logic                    is_rel;
    state_code_t             code;
    logic [HIST_W-1:0]       hist_out;
    logic [TIME_W-1:0]       press_out;
    logic [TIME_W-1:0]       rel_out;
    logic                    all_up_out;

    assign active_vec = active_mask_reg[BUTTON_COUNT-1:0];
    assign level_vec  = levels_reg[BUTTON_COUNT-1:0];
    assign active     = active_vec[cmd.idx];

    // zero samples behaves as one
    assign n_eff    = (press_samples_reg == '0) ? PS_W'(1) : press_samples_reg;
    assign win_wide = ((HIST_W + 1)'(1) << ({1'b0, n_eff} + 6'd1)) - (HIST_W + 1)'(1);
    assign win      = win_wide[HIST_W-1:0];
    assign ones_n   = (HIST_W'(1) << n_eff) - HIST_W'(1);
    assign rel_pat  = HIST_W'(1) << n_eff;

    assign hist_new = {hist_reg[cmd.idx][HIST_W-2:0], level_vec[cmd.idx]};
    assign h        = hist_new & win;
    assign is_press = active && (h == ones_n) && !flag_reg[cmd.idx];
    assign is_rel   = active && (h == rel_pat) && flag_reg[cmd.idx];

    always_comb
    begin
        if (!active)
            code = ST_UP;
        else if (is_press)
            code = ST_PRESSED;
        else if (is_rel)
            code = ST_RELEASED;
        else if (h == win)
            code = ST_DOWN;
        else if (h == '0)
            code = ST_UP;
        else
            code = ST_UNKNOWN;
    end

    assign hist_out   = active ? hist_new : hist_reg[cmd.idx];
    assign press_out  = is_press ? now_reg : press_at_reg[cmd.idx];
    assign rel_out    = is_rel ? now_reg : rel_at_reg[cmd.idx];
    assign all_up_out = cmd.last && all_up_reg && (code == ST_UP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_mask_reg   <= '0;
            press_samples_reg <= PS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ACTIVE_MASK:   active_mask_reg   <= cfg_data[MASK_W-1:0];
                REG_PRESS_SAMPLES: press_samples_reg <= cfg_data[PS_W-1:0];
                default:           active_mask_reg   <= active_mask_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            levels_reg <= s_tdata[LEVEL_W-1:0];
            now_reg    <= s_tdata[LEVEL_W +: TIME_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                hist_reg[i]     <= '0;
                flag_reg[i]     <= 1'b0;
                press_at_reg[i] <= '0;
                rel_at_reg[i]   <= '0;
            end
        end
        else if (cmd.step && active)
        begin
            hist_reg[cmd.idx]     <= hist_new;
            press_at_reg[cmd.idx] <= press_out;
            rel_at_reg[cmd.idx]   <= rel_out;
            if (is_press)
                flag_reg[cmd.idx] <= 1'b1;
            else if (is_rel)
                flag_reg[cmd.idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_up_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                all_up_reg <= 1'b1;
            else if (cmd.step)
                all_up_reg <= all_up_reg && (code == ST_UP);

            if (cmd.step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            out_idx_reg    <= BIDX_W'(cmd.idx);
            out_code_reg   <= code;
            out_hist_reg   <= hist_out;
            out_press_reg  <= press_out;
            out_rel_reg    <= rel_out;
            out_all_up_reg <= all_up_out;
            out_last_reg   <= cmd.last;
        end
    end

    assign stat.out_hold = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_rel_reg, out_press_reg, out_hist_reg,
                       out_code_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_all_up_reg;

endmodule

// ===== hdl/mbhd_checker.sv =====
`include "assert_macros.svh"

module mbhd_checker
    import mbhd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tlast,
    input logic             m_tuser
);

    // stalled word stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    // one tick at a time: busy right after a word is taken
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // the final word of a tick belongs to the highest button
    `ASSERT_IMPL(a_last_index, clk, rst_n, m_tvalid && m_tlast, m_tdata[2:0] == LAST_INDEX)
    // all_up only rides on the final word
    `ASSERT_IMPL(a_all_up_last, clk, rst_n, m_tvalid && !m_tlast, !m_tuser)
    `ASSERT_IMPL(a_code_range, clk, rst_n, m_tvalid, m_tdata[5:3] <= CODE_W'(ST_UP))

endmodule

bind multi_button_history_debouncer_unit mbhd_checker u_mbhd_checker (.*);
